// File: sv/grid_wall_follower_defines.svh
// assertion macros used by the checker file
`ifndef GRID_WALL_FOLLOWER_DEFINES_SVH
`define GRID_WALL_FOLLOWER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define GWF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GWF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/gwf_pkg.sv
package gwf_pkg;

  // map and walk limits
  localparam int GRID_SIZE = 16;
  localparam int MAX_STEPS = 1024;

  // port field widths
  localparam int COORD_W   = 4;
  localparam int MOVES_W   = 11;
  localparam int OUTCOME_W = 2;
  localparam int HEADING_W = 2;

  // internal widths
  localparam int POS_W = ($clog2(GRID_SIZE) > COORD_W) ? $clog2(GRID_SIZE) : COORD_W;
  localparam int IDX_W = $clog2(GRID_SIZE);
  localparam int CNT_W = $clog2(MAX_STEPS + 1);

  // request opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_WALK  = 1'b1;

  // walk outcome codes
  typedef enum logic [OUTCOME_W-1:0] {
    OUT_EXITED,
    OUT_RETURNED,
    OUT_TRAPPED,
    OUT_LIMIT
  } outcome_t;

  // move directions
  typedef enum logic [HEADING_W-1:0] {
    HD_DOWN,
    HD_RIGHT,
    HD_UP,
    HD_LEFT
  } heading_t;

endpackage

// File: sv/grid_wall_follower.sv
// Wall-following walker over a GRID_SIZE x GRID_SIZE wall map. A write request
// (opcode 0) sets or clears one map cell; writes outside the grid are dropped.
// After reset every cell is a wall. A walk request (opcode 1) starts at the
// given cell and heading and produces exactly one result: exited (reached the
// last column from another column), returned (back on the start cell after at
// least one move), trapped (no open neighbour, or a start cell outside the
// grid) or step limit (MAX_STEPS moves). in_stall stays high while a walk runs.
// Each move runs the end tests for the current cell and then the direction
// probes, and the result is posted last; the single neighbour probe unit tests
// one direction per cycle. The result sits in an output register, so the next
// request is taken while an earlier result still waits.
module grid_wall_follower (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [gwf_pkg::COORD_W-1:0]   in_row,
  input  logic [gwf_pkg::COORD_W-1:0]   in_col,
  input  logic                          in_is_wall,
  input  logic [gwf_pkg::HEADING_W-1:0] in_start_heading,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gwf_pkg::OUTCOME_W-1:0] out_outcome,
  output logic [gwf_pkg::COORD_W-1:0]   out_end_row,
  output logic [gwf_pkg::COORD_W-1:0]   out_end_col,
  output logic [gwf_pkg::MOVES_W-1:0]   out_moves_taken
);
  import gwf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PROBE,
    ST_POST
  } state_t;

  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(GRID_SIZE - 1);
  localparam logic [CNT_W-1:0] STEP_CAP  = CNT_W'(MAX_STEPS);
  localparam logic [1:0]       LAST_TRY  = 2'd3;

  state_t                 state_r;
  logic [GRID_SIZE-1:0]   wall_map_r [GRID_SIZE];
  logic [POS_W-1:0]       cur_row_r;
  logic [POS_W-1:0]       cur_col_r;
  logic [POS_W-1:0]       start_row_r;
  logic [POS_W-1:0]       start_col_r;
  heading_t               heading_r;
  logic [1:0]             try_r;
  logic [CNT_W-1:0]       move_cnt_r;
  outcome_t               outcome_r;
  logic                   out_valid_r;
  outcome_t               out_outcome_r;
  logic [COORD_W-1:0]     out_row_r;
  logic [COORD_W-1:0]     out_col_r;
  logic [MOVES_W-1:0]     out_moves_r;

  logic                   in_accept;
  logic                   out_free;
  logic [POS_W-1:0]       req_row;
  logic [POS_W-1:0]       req_col;
  logic                   req_in_grid;
  heading_t               probe_dir;
  logic [POS_W-1:0]       nb_row;
  logic [POS_W-1:0]       nb_col;
  logic                   nb_inside;
  logic                   nb_open;
  logic                   at_exit;
  logic                   at_return;
  logic                   at_limit;

  // handshake
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // request cell, widened to the position width
  assign req_row     = POS_W'(in_row);
  assign req_col     = POS_W'(in_col);
  assign req_in_grid = (int'(in_row) < GRID_SIZE) && (int'(in_col) < GRID_SIZE);

  // neighbour probe: one direction per cycle
  assign probe_dir = heading_t'(2'(heading_r + try_r));

  always_comb begin
    nb_row    = cur_row_r;
    nb_col    = cur_col_r;
    nb_inside = 1'b0;
    unique case (probe_dir)
      HD_DOWN: begin
        nb_inside = (cur_row_r != LAST_POS);
        nb_row    = cur_row_r + 1'b1;
      end
      HD_RIGHT: begin
        nb_inside = (cur_col_r != LAST_POS);
        nb_col    = cur_col_r + 1'b1;
      end
      HD_UP: begin
        nb_inside = (cur_row_r != '0);
        nb_row    = cur_row_r - 1'b1;
      end
      HD_LEFT: begin
        nb_inside = (cur_col_r != '0);
        nb_col    = cur_col_r - 1'b1;
      end
    endcase
  end

  assign nb_open = nb_inside && !wall_map_r[nb_row[IDX_W-1:0]][nb_col[IDX_W-1:0]];

  // end tests for the current cell
  assign at_exit   = (cur_col_r == LAST_POS) && (cur_col_r != start_col_r);
  assign at_return = (cur_row_r == start_row_r) && (cur_col_r == start_col_r) &&
                     (move_cnt_r != '0);
  assign at_limit  = (move_cnt_r == STEP_CAP);

  // sequencer, map and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      heading_r   <= HD_DOWN;
      try_r       <= '0;
      move_cnt_r  <= '0;
      for (int i = 0; i < GRID_SIZE; i++) begin
        wall_map_r[i] <= '1;
      end
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_POST)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            if (in_opcode == OP_WRITE) begin
              if (req_in_grid) begin
                wall_map_r[req_row[IDX_W-1:0]][req_col[IDX_W-1:0]] <= in_is_wall;
              end
            end else begin
              cur_row_r   <= req_row;
              cur_col_r   <= req_col;
              start_row_r <= req_row;
              start_col_r <= req_col;
              heading_r   <= heading_t'(in_start_heading);
              move_cnt_r  <= '0;
              try_r       <= '0;
              if (req_in_grid) begin
                state_r <= ST_CHECK;
              end else begin
                outcome_r <= OUT_TRAPPED;
                state_r   <= ST_POST;
              end
            end
          end
        end
        ST_CHECK: begin
          priority if (at_exit) begin
            outcome_r <= OUT_EXITED;
            state_r   <= ST_POST;
          end else if (at_return) begin
            outcome_r <= OUT_RETURNED;
            state_r   <= ST_POST;
          end else if (at_limit) begin
            outcome_r <= OUT_LIMIT;
            state_r   <= ST_POST;
          end else begin
            try_r   <= '0;
            state_r <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          priority if (nb_open) begin
            cur_row_r  <= nb_row;
            cur_col_r  <= nb_col;
            heading_r  <= heading_t'(2'(probe_dir - 2'd1));
            move_cnt_r <= move_cnt_r + 1'b1;
            state_r    <= ST_CHECK;
          end else if (try_r == LAST_TRY) begin
            outcome_r <= OUT_TRAPPED;
            state_r   <= ST_POST;
          end else begin
            try_r <= try_r + 1'b1;
          end
        end
        ST_POST: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_outcome_r <= outcome_r;
            out_row_r     <= COORD_W'(cur_row_r);
            out_col_r     <= COORD_W'(cur_col_r);
            out_moves_r   <= MOVES_W'(move_cnt_r);
            state_r       <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // result ports
  assign out_valid       = out_valid_r;
  assign out_outcome     = out_outcome_r;
  assign out_end_row     = out_row_r;
  assign out_end_col     = out_col_r;
  assign out_moves_taken = out_moves_r;

endmodule

// File: sv/gwf_checker.sv
`include "grid_wall_follower_defines.svh"

module gwf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_opcode,
  input logic [gwf_pkg::COORD_W-1:0]   in_row,
  input logic [gwf_pkg::COORD_W-1:0]   in_col,
  input logic                          in_is_wall,
  input logic [gwf_pkg::HEADING_W-1:0] in_start_heading,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [gwf_pkg::OUTCOME_W-1:0] out_outcome,
  input logic [gwf_pkg::COORD_W-1:0]   out_end_row,
  input logic [gwf_pkg::COORD_W-1:0]   out_end_col,
  input logic [gwf_pkg::MOVES_W-1:0]   out_moves_taken
);
  import gwf_pkg::*;

  // a stalled result holds
  `GWF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_outcome) && $stable(out_end_row) && $stable(out_end_col) && $stable(out_moves_taken), "stalled result changed")

  // a walk request keeps the input side busy on the next cycle
  `GWF_ASSERT_NEXT(a_walk_busy, in_valid && !in_stall && (in_opcode == OP_WALK), in_stall, "walk request did not block input")

  // an exit ends in the last column
  `GWF_ASSERT_NOW(a_exit_col, out_valid && (out_outcome == OUT_EXITED), out_end_col == COORD_W'(GRID_SIZE - 1), "exit away from last column")

  // a step-limit result carries the full step count
  `GWF_ASSERT_NOW(a_limit_cnt, out_valid && (out_outcome == OUT_LIMIT), out_moves_taken == MOVES_W'(MAX_STEPS), "limit with wrong move count")

  // a return needs at least one move
  `GWF_ASSERT_NOW(a_return_moved, out_valid && (out_outcome == OUT_RETURNED), out_moves_taken != '0, "return without a move")

endmodule

bind grid_wall_follower gwf_checker u_gwf_checker (.*);
